>>> rtl/kbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kbt_pkg;

    localparam int MaxBlock = 10;
    localparam int CntW     = 4;
    localparam int KeyW     = 40;
    localparam int DigW     = 4;
    localparam int CfgIdxW  = 2;

    localparam logic [7:0] PAD_CHAR   = 8'h7A;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    localparam logic [CfgIdxW-1:0] CFG_DIRECTION  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_BLOCK_LEN  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEY_DIGITS = 2'd2;

    localparam logic [CntW-1:0] BLOCK_LEN_RESET  = 4'd8;
    localparam logic [KeyW-1:0] KEY_DIGITS_RESET = 40'h9876543210;

    typedef logic [MaxBlock-1:0][CntW-1:0] rank_arr_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    typedef struct packed {
        logic accept;
        logic emit_step;
        logic emit_done;
    } kbt_cmd_t;

    typedef struct packed {
        logic emit_req;
        logic step_last;
        logic out_free;
    } kbt_status_t;

    function automatic logic [CntW-1:0] eff_len(input logic [CntW-1:0] len);
        logic [CntW-1:0] n;
        n = len;
        if (n == '0) n = CntW'(1);
        if (n > CntW'(MaxBlock)) n = CntW'(MaxBlock);
        return n;
    endfunction

    // Rank of each column among the active columns: by digit, ties broken by column index.
    function automatic rank_arr_t key_ranks(input logic [KeyW-1:0] key,
                                            input logic [CntW-1:0] n);
        rank_arr_t ranks;
        logic [MaxBlock-1:0] below;
        logic [DigW-1:0] dj;
        logic [DigW-1:0] di;
        for (int j = 0; j < MaxBlock; j++) begin
            dj = key[DigW*j +: DigW];
            for (int i = 0; i < MaxBlock; i++) begin
                di = key[DigW*i +: DigW];
                below[i] = (CntW'(i) < n) && ((di < dj) || ((di == dj) && (i < j)));
            end
            ranks[j] = CntW'($countones(below));
        end
        return ranks;
    endfunction

    function automatic logic [CntW-1:0] find_col(input rank_arr_t ranks,
                                                 input logic [CntW-1:0] target,
                                                 input logic [CntW-1:0] n);
        logic [CntW-1:0] col;
        col = '0;
        for (int j = 0; j < MaxBlock; j++) begin
            if ((ranks[j] == target) && (CntW'(j) < n)) col = CntW'(j);
        end
        return col;
    endfunction

endpackage

`default_nettype wire

>>> rtl/kbt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kbt_ctrl
    import kbt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire kbt_status_t status,
    output kbt_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.emit_step = 1'b0;
        cmd.emit_done = 1'b0;
        in_stall      = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid && status.emit_req) state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_step = status.out_free;
                if (status.out_free && status.step_last)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/kbt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module kbt_datapath
    import kbt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [KeyW-1:0]    cfg_data,
    input  wire logic [7:0]         in_char,
    input  wire logic               in_last,
    input  wire kbt_cmd_t           cmd,
    output kbt_status_t             status,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              out_char,
    output logic                    run_last,
    output logic                    message_end
);

    logic            direction_reg;
    logic [CntW-1:0] block_len_reg;
    logic [KeyW-1:0] key_digits_reg;

    logic [7:0] row_buffer [MaxBlock];

    logic [CntW-1:0] fill_reg;
    logic [CntW-1:0] fill_next;
    logic [CntW-1:0] k_reg;
    logic [CntW-1:0] k_next;
    logic            last_reg;
    logic            last_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [7:0]      out_char_reg;
    logic            run_last_reg;
    logic            message_end_reg;

    logic [CntW-1:0] n;
    rank_arr_t       ranks;
    logic [CntW-1:0] fill0;
    logic [CntW-1:0] fill1;
    logic [CntW-1:0] dec_col;
    logic [CntW-1:0] enc_col;
    logic            wr_en;
    logic [CntW-1:0] wr_idx;
    logic            is_space;
    logic            encrypt;
    logic [CntW-1:0] rd_idx;
    logic            rd_pad;

    always_comb
    begin
        n        = eff_len(block_len_reg);
        ranks    = key_ranks(key_digits_reg, n);
        fill0    = (fill_reg >= n) ? '0 : fill_reg;
        dec_col  = find_col(ranks, fill0, n);
        enc_col  = find_col(ranks, k_reg, n);
        is_space = (in_char == SPACE_CHAR);
        encrypt  = (direction_reg == DIR_ENCRYPT);

        if (encrypt)
        begin
            wr_en           = !is_space;
            wr_idx          = fill0;
            fill1           = fill0 + CntW'(!is_space);
            status.emit_req = (fill1 != '0) && ((fill1 >= n) || in_last);
        end
        else
        begin
            wr_en           = 1'b1;
            wr_idx          = dec_col;
            fill1           = fill0 + CntW'(1);
            status.emit_req = (fill1 >= n);
        end

        if (encrypt)
        begin
            rd_idx = enc_col;
            rd_pad = (enc_col >= fill_reg);
        end
        else
        begin
            rd_idx = k_reg;
            rd_pad = 1'b0;
        end

        status.step_last = (k_reg == n - CntW'(1));
        status.out_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        fill_next      = fill_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (!out_stall) out_valid_next = 1'b0;
        if (cmd.accept)
        begin
            k_next    = '0;
            last_next = in_last;
            if (!encrypt && !status.emit_req && in_last) fill_next = '0;
            else fill_next = fill1;
        end
        if (cmd.emit_step)
        begin
            k_next         = k_reg + CntW'(1);
            out_valid_next = 1'b1;
        end
        if (cmd.emit_done) fill_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg  <= DIR_ENCRYPT;
            block_len_reg  <= BLOCK_LEN_RESET;
            key_digits_reg <= KEY_DIGITS_RESET;
            fill_reg       <= '0;
            k_reg          <= '0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DIRECTION:  direction_reg  <= cfg_data[0];
                    CFG_BLOCK_LEN:  block_len_reg  <= cfg_data[CntW-1:0];
                    CFG_KEY_DIGITS: key_digits_reg <= cfg_data;
                    default:        ;
                endcase
            end
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en) row_buffer[wr_idx] <= in_char;
        if (cmd.emit_step)
        begin
            out_char_reg    <= rd_pad ? PAD_CHAR : row_buffer[rd_idx];
            run_last_reg    <= status.step_last;
            message_end_reg <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign run_last    = run_last_reg;
    assign message_end = message_end_reg;

endmodule

`default_nettype wire

>>> rtl/keyed_block_transposition_unit.sv
// Output: a character that completes a row moves the controller to ST_EMIT, where each drain
// step registers one output word; the row's n words follow one per cycle while the output is
// not stalled. Throughput: a character that completes no row leaves the input free for the next;
// one that completes a row blocks input while the row buffer's single read port drains it.
// Reset: clears the registers to their reset values, the fill count and the output valid;
// the row buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module keyed_block_transposition_unit
    import kbt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [KeyW-1:0]    cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         in_char,
    input  wire logic               in_last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              out_char,
    output logic                    run_last,
    output logic                    message_end
);

    kbt_cmd_t    cmd;
    kbt_status_t status;

    assign cfg_ready = 1'b1;

    kbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    kbt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_char     (in_char),
        .in_last     (in_last),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .message_end (message_end)
    );

    // A character that completes a row blocks input until the row has drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && status.emit_req |=> in_stall)
        else $error("input not blocked after a row completed");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |=> out_valid)
        else $error("output word lost after a drain step");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_done |=> !in_stall)
        else $error("input still blocked after the row drained");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |=> run_last == $past(status.step_last))
        else $error("row end flag does not match the drain position");

endmodule

`default_nettype wire
